// ===== hdl/pli_pkg.sv =====
// Package for the piecewise linear interpolator: mode and status codes,
// controller state type, datapath command/status structs. No dependencies.
package pli_pkg;

    localparam int MAX_POINTS_DEFAULT = 256;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_EVAL   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_EMPTY          = 2'd1,
        ST_NOT_INCREASING = 2'd2,
        ST_FULL           = 2'd3
    } status_t;

    // source of the output word
    typedef enum logic [1:0] {
        SEL_ZERO    = 2'd0,
        SEL_LAST_Y  = 2'd1,
        SEL_FIRST_Y = 2'd2,
        SEL_INTERP  = 2'd3
    } outsel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST_RD,
        S_LAST_WAIT,
        S_FIRST_RD,
        S_FIRST_WAIT,
        S_SRCH_RD,
        S_SRCH_WAIT,
        S_LO_RD,
        S_LO_WAIT,
        S_HI_WAIT,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;       // capture input word
        logic rd_last;       // read entry count-1
        logic rd_first;      // read entry 0
        logic rd_mid;        // read entry mid
        logic rd_lo;         // read entry lo
        logic rd_hi;         // read entry lo+1
        logic cap_last;      // latch last entry
        logic cap_first;     // latch first entry
        logic step_search;   // narrow search by mid data
        logic cap_lo;        // latch lo entry
        logic cap_hi;        // latch hi entry
        logic do_mul;        // form product
        logic div_start;     // set up divider
        logic div_step;      // one restoring step
        logic finish;        // form result
        logic write_pt;      // append point
        logic clear_cnt;     // empty table
        logic set_result;    // latch output word
        outsel_t out_sel;    // source of the output word
        status_t out_status;
    } pli_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic full;
        logic below_first;
        logic above_last;
        logic not_increasing;
        logic search_done;
        logic div_done;
    } pli_stat_t;

endpackage

// ===== hdl/pli_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hdl/pli_datapath.sv =====
// Datapath: breakpoint memories, search registers, multiplier, serial divider.
// Depends on pli_pkg and pli_ram.
module pli_datapath #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pli_pkg::pli_cmd_t   cmd,
    output pli_pkg::pli_stat_t  stat,
    input  logic signed [31:0]  x_value,
    input  logic signed [31:0]  y_value,
    output logic signed [31:0]  result_value,
    output logic [1:0]          status
);
    import pli_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] count_reg, count_next;
    logic signed [31:0] xq_reg, yq_reg;
    logic signed [31:0] last_x_reg, last_y_reg, first_y_reg;
    logic signed [31:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [AW-1:0] lo_reg, hi_reg, mid;
    logic [AW-1:0] addr;
    logic signed [31:0] xr, yr;
    logic [63:0] prod_reg;
    logic [32:0] span_reg;
    logic [63:0] quo_reg;
    logic [33:0] rem_reg;
    logic [6:0] div_cnt_reg;
    logic neg_reg;
    logic signed [31:0] result_reg;
    logic [1:0] status_reg;
    logic signed [31:0] interp;
    logic [CW-1:0] count_m1;
    logic [31:0] dx_w;
    logic [31:0] mag_w;

    assign count_m1 = count_reg - CW'(1);
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    // dx and |dy| each fit 32 bits unsigned
    assign dx_w  = 32'(xq_reg - x0_reg);
    assign mag_w = (y1_reg < y0_reg) ? 32'(y0_reg - y1_reg) : 32'(y1_reg - y0_reg);

    always_comb
    begin
        addr = count_reg[AW-1:0];
        if (cmd.rd_last)
        begin
            addr = count_m1[AW-1:0];
        end
        else if (cmd.rd_first)
        begin
            addr = '0;
        end
        else if (cmd.rd_mid)
        begin
            addr = mid;
        end
        else if (cmd.rd_lo)
        begin
            addr = lo_reg;
        end
        else if (cmd.rd_hi)
        begin
            addr = lo_reg + AW'(1);
        end
    end

    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_xram (
        .clk(clk), .we(cmd.write_pt), .addr(addr), .wdata(xq_reg), .rdata(xr));
    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_yram (
        .clk(clk), .we(cmd.write_pt), .addr(addr), .wdata(yq_reg), .rdata(yr));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_cnt)
        begin
            count_next = '0;
        end
        else if (cmd.write_pt)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            xq_reg <= x_value;
            yq_reg <= y_value;
            lo_reg <= '0;
            hi_reg <= count_m1[AW-1:0];
        end
        if (cmd.cap_last)
        begin
            last_x_reg <= xr;
            last_y_reg <= yr;
        end
        if (cmd.cap_first)
        begin
            x0_reg      <= xr;
            first_y_reg <= yr;
        end
        if (cmd.step_search)
        begin
            if (xq_reg < xr)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid;
            end
        end
        if (cmd.cap_lo)
        begin
            x0_reg <= xr;
            y0_reg <= yr;
        end
        if (cmd.cap_hi)
        begin
            x1_reg <= xr;
            y1_reg <= yr;
        end
        if (cmd.do_mul)
        begin
            prod_reg <= 64'(dx_w) * 64'(mag_w);
            neg_reg  <= (y1_reg < y0_reg);
            span_reg <= {1'b0, 32'(x1_reg - x0_reg)};
        end
        if (cmd.div_start)
        begin
            quo_reg     <= prod_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            // restoring division, one quotient bit a cycle
            if ({rem_reg[32:0], quo_reg[63]} >= {1'b0, span_reg})
            begin
                rem_reg <= {rem_reg[32:0], quo_reg[63]} - {1'b0, span_reg};
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[32:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 7'd1;
        end
        if (cmd.set_result)
        begin
            status_reg <= cmd.out_status;
            case (cmd.out_sel)
                SEL_ZERO:    result_reg <= '0;
                SEL_LAST_Y:  result_reg <= last_y_reg;
                SEL_FIRST_Y: result_reg <= first_y_reg;
                default:     result_reg <= interp;
            endcase
        end
    end

    assign interp = neg_reg ? (y0_reg - quo_reg[31:0]) : (y0_reg + quo_reg[31:0]);

    assign stat.count_zero     = (count_reg == '0);
    assign stat.full           = (count_reg >= CW'(MAX_POINTS));
    assign stat.below_first    = (xq_reg < x0_reg);
    assign stat.above_last     = (xq_reg >= last_x_reg);
    assign stat.not_increasing = (xq_reg <= last_x_reg);
    assign stat.search_done    = ((hi_reg - lo_reg) <= AW'(1));
    assign stat.div_done       = (div_cnt_reg == 7'd64);

    assign result_value = result_reg;
    assign status       = status_reg;
endmodule

// ===== hdl/pli_ctrl.sv =====
// Controller state machine for the interpolator; issues datapath commands.
// Depends on pli_pkg.
module pli_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    output logic               out_valid,
    input  logic               out_ready,
    output pli_pkg::pli_cmd_t  cmd,
    input  pli_pkg::pli_stat_t stat
);
    import pli_pkg::*;

    state_t state_reg, state_next;
    mode_t  mode_reg;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode_t'(mode);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (accept) state_next = S_LAST_RD;
            S_LAST_RD:    state_next = S_LAST_WAIT;
            S_LAST_WAIT:  state_next = (mode_reg == MODE_EVAL && !stat.count_zero)
                                       ? S_FIRST_RD : S_OUT;
            S_FIRST_RD:   state_next = S_FIRST_WAIT;
            S_FIRST_WAIT: state_next = S_SRCH_RD;
            S_SRCH_RD:
            begin
                // first x is latched by now: settle out-of-range queries here
                if (stat.below_first || stat.above_last)
                    state_next = S_OUT;
                else if (stat.search_done)
                    state_next = S_LO_RD;
                else
                    state_next = S_SRCH_WAIT;
            end
            S_SRCH_WAIT:  state_next = S_SRCH_RD;
            S_LO_RD:      state_next = S_LO_WAIT;
            S_LO_WAIT:    state_next = S_HI_WAIT;
            S_HI_WAIT:    state_next = S_MUL;
            S_MUL:        state_next = S_DIV_INIT;
            S_DIV_INIT:   state_next = S_DIV;
            S_DIV:        state_next = stat.div_done ? S_FIN : S_DIV;
            S_FIN:        state_next = S_IDLE;
            S_OUT:        state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.out_sel    = SEL_ZERO;
        cmd.out_status = ST_OK;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:      cmd.load_in = accept;
            S_LAST_RD:   cmd.rd_last = 1'b1;
            S_LAST_WAIT: cmd.cap_last = 1'b1;
            S_FIRST_RD:  cmd.rd_first = 1'b1;
            S_FIRST_WAIT:
            begin
                cmd.cap_first = 1'b1;
            end
            S_SRCH_RD:   cmd.rd_mid = !stat.search_done;
            S_SRCH_WAIT: cmd.step_search = 1'b1;
            S_LO_RD:     cmd.rd_lo = 1'b1;
            S_LO_WAIT:
            begin
                cmd.cap_lo = 1'b1;
                cmd.rd_hi  = 1'b1;
            end
            S_HI_WAIT:   cmd.cap_hi = 1'b1;
            S_MUL:       cmd.do_mul = 1'b1;
            S_DIV_INIT:  cmd.div_start = 1'b1;
            S_DIV:       cmd.div_step = !stat.div_done;
            S_FIN:
            begin
                cmd.set_result = 1'b1;
                cmd.out_sel    = SEL_INTERP;
                out_valid_next = 1'b1;
            end
            S_OUT:
            begin
                cmd.set_result = 1'b1;
                out_valid_next = 1'b1;
                case (mode_reg)
                    MODE_APPEND:
                    begin
                        if (stat.full)
                            cmd.out_status = ST_FULL;
                        else if (!stat.count_zero && stat.not_increasing)
                            cmd.out_status = ST_NOT_INCREASING;
                        else
                            cmd.write_pt = 1'b1;
                    end
                    MODE_EVAL:
                    begin
                        if (stat.count_zero)
                            cmd.out_status = ST_EMPTY;
                        else if (stat.below_first)
                            cmd.out_sel = SEL_FIRST_Y;
                        else
                            cmd.out_sel = SEL_LAST_Y;
                    end
                    MODE_CLEAR: cmd.clear_cnt = 1'b1;
                    default:    cmd.out_sel = SEL_ZERO;
                endcase
            end
            default: ;
        endcase
    end
endmodule

// ===== hdl/piecewise_linear_interpolator.sv =====
// Top level of the piecewise linear interpolator: controller plus datapath.
// Depends on pli_pkg, pli_ctrl, pli_datapath (and pli_ram below it).
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------
//   input   | in_valid / in_ready   | mode, x_value, y_value
//   output  | out_valid / out_ready | result_value, status
//
// One word in flight at a time. Append, clear, the undefined mode and
// evaluate of an empty table go from reading the last entry straight
// to the result; an out-of-range evaluate also reads the first entry
// and is settled before the search. An interior evaluate runs the
// memory probes of the search and then the 64-step restoring divider.
// Reset empties the table at once; table contents stay undefined until
// written. A stalled result holds the block: the next word can be taken
// in the cycle after the result has been delivered.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [31:0] x_value,
    input  logic signed [31:0] y_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_value,
    output logic [1:0]         status
);
    import pli_pkg::*;

    pli_cmd_t  cmd;
    pli_stat_t stat;

    // sequence each word through the datapath
    pli_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .out_valid(out_valid), .out_ready(out_ready),
        .cmd(cmd), .stat(stat)
    );

    // hold table, search and divide
    pli_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .x_value(x_value), .y_value(y_value),
        .result_value(result_value), .status(status)
    );
endmodule
